// ----- sv/vt52_text_terminal_top_defines.svh -----
// Assertion macros used by the terminal's checker file.
`ifndef VT52_TEXT_TERMINAL_TOP_DEFINES_SVH
`define VT52_TEXT_TERMINAL_TOP_DEFINES_SVH

// Plain clocked assertion, also evaluated while reset is held.
`define VT52_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

// Clocked assertion that is switched off while reset is held.
`define VT52_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`endif

// ----- sv/vt52_pkg.sv -----
// Package: types, character codes and defaults of the text terminal.
`default_nettype none
package vt52_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 32;
    localparam int DEF_ROWS    = 8;

    typedef logic [7:0] t_char;

    // Command opcodes
    typedef enum logic {
        OP_FEED = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    // Configuration register indexes
    typedef enum logic {
        CFG_ROW_BIAS = 1'b0,
        CFG_COL_BIAS = 1'b1
    } t_cfg_idx;

    localparam t_char ROW_BIAS_RST = 8'd32;
    localparam t_char COL_BIAS_RST = 8'd32;

    // Character codes
    localparam t_char CH_LF        = 8'h0A;
    localparam t_char CH_CR        = 8'h0D;
    localparam t_char CH_ESC       = 8'h1B;
    localparam t_char CH_UP        = 8'h41; // 'A'
    localparam t_char CH_DOWN      = 8'h42; // 'B'
    localparam t_char CH_RIGHT     = 8'h43; // 'C'
    localparam t_char CH_LEFT      = 8'h44; // 'D'
    localparam t_char CH_CLEAR     = 8'h45; // 'E'
    localparam t_char CH_HOME      = 8'h48; // 'H'
    localparam t_char CH_ERASE_EOS = 8'h4A; // 'J'
    localparam t_char CH_ERASE_EOL = 8'h4B; // 'K'
    localparam t_char CH_POS       = 8'h59; // 'Y'

    // Escape parser phase
    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_Y    = 2'd2,
        PH_YROW = 2'd3
    } t_phase;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FEED,
        ST_FLUSH,
        ST_POST,
        ST_SCROLL,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- sv/vt52_cmd_if.sv -----
// Command channel interface: character feed and cell read requests.
`default_nettype none
interface vt52_cmd_if import vt52_pkg::*;;
    logic       valid;
    logic       ready;
    logic       opcode;
    t_char      char_code;
    logic       end_of_string;
    logic [2:0] read_row;
    logic [4:0] read_col;

    modport source (
        output valid, opcode, char_code, end_of_string, read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, opcode, char_code, end_of_string, read_row, read_col,
        output ready
    );
endinterface
`default_nettype wire

// ----- sv/vt52_rsp_if.sv -----
// Response channel interface: cursor, cell and escape status.
`default_nettype none
interface vt52_rsp_if import vt52_pkg::*;;
    logic       valid;
    logic       ready;
    logic [4:0] cursor_col;
    logic [2:0] cursor_row;
    t_char      cell_char;
    logic       escape_pending;

    modport source (
        output valid, cursor_col, cursor_row, cell_char, escape_pending,
        input  ready
    );
    modport sink (
        input  valid, cursor_col, cursor_row, cell_char, escape_pending,
        output ready
    );
endinterface
`default_nettype wire

// ----- sv/vt52_text_terminal_top.sv -----
// Top level of the text terminal: screen memory, cursor and escape sequencer.
//
// Channel  Dir  Handshake        Payload
// i_cmd    in   valid/ready      opcode, char_code, end_of_string, read_row, read_col
// o_rsp    out  valid/ready      cursor_col, cursor_row, cell_char, escape_pending
// cfg      in   i_cfg_we only    i_cfg_addr, i_cfg_data
//
// A read goes through ST_DONE, a plain character or a cursor escape through ST_FEED,
// to the output register. Scroll copies rows up, then clears the last row; ESC E clears
// all cells, ESC J / ESC K one cell per cycle; a flush renders bytes via ST_FLUSH.
// After reset a clearing pass over all ROWS*COLUMNS cells runs with i_cmd.ready low.
// i_cmd.ready is high in idle; a stalled result waits in the output register
// and the next item finishes only once that register is free.
`default_nettype none
module vt52_text_terminal_top import vt52_pkg::*; #(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_addr,
    input  t_char    i_cfg_data,
    vt52_cmd_if.sink   i_cmd,
    vt52_rsp_if.source o_rsp
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int CELL_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [CELL_W-1:0] CELL_LAST  = CELL_W'(CELLS - 1);
    localparam logic [CELL_W-1:0] LAST_ROW0  = CELL_W'(CELLS - COLUMNS);
    localparam logic [CELL_W-1:0] SCROLL_SRC = CELL_W'(COLUMNS);

    // Screen memory and its ports
    t_char              r_mem [CELLS];
    t_char              r_rdata;
    logic               mem_we;
    logic [CELL_W-1:0]  mem_wa;
    t_char              mem_wd;
    logic               mem_re;
    logic [CELL_W-1:0]  mem_ra;

    // Control and cursor state
    t_state             r_state, n_state;
    logic               r_init, n_init;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    t_phase             r_phase, n_phase;
    t_char              r_held, n_held;
    t_char              r_row_bias, r_col_bias;
    t_char              r_char, n_char;
    logic               r_eos, n_eos;
    logic               r_cell_ok, n_cell_ok;
    logic [1:0]         r_fl_idx, n_fl_idx;
    logic [1:0]         r_fl_last, n_fl_last;
    logic [CELL_W-1:0]  r_ptr, n_ptr;
    logic [CELL_W-1:0]  r_end, n_end;
    logic               r_cp_valid;
    logic [CELL_W-1:0]  r_cp_addr;

    // Output register
    logic               r_out_valid;
    logic [4:0]         r_o_col;
    logic [2:0]         r_o_row;
    t_char              r_o_cell;
    logic               r_o_esc;

    logic               fin;
    logic               out_load;

    // Addresses
    logic               rd_ok;
    logic [CELL_W-1:0]  rd_addr;
    logic [CELL_W-1:0]  cur_addr;
    logic [CELL_W-1:0]  eol_addr;

    assign rd_ok    = (int'(i_cmd.read_row) < ROWS) && (int'(i_cmd.read_col) < COLUMNS);
    assign rd_addr  = CELL_W'(int'(i_cmd.read_row) * COLUMNS + int'(i_cmd.read_col));
    assign cur_addr = CELL_W'(int'(r_row) * COLUMNS + int'(r_col));
    assign eol_addr = CELL_W'(int'(r_row) * COLUMNS + COLUMNS - 1);

    // ESC Y target position
    logic [8:0] pos_r_diff, pos_c_diff;
    logic       pos_ok;

    assign pos_r_diff = {1'b0, r_held} - {1'b0, r_row_bias};
    assign pos_c_diff = {1'b0, r_char} - {1'b0, r_col_bias};
    assign pos_ok     = !pos_r_diff[8] && (int'(pos_r_diff[7:0]) < ROWS) &&
                        !pos_c_diff[8] && (int'(pos_c_diff[7:0]) < COLUMNS);

    // Byte rendered as text: fed character or a flushed escape byte
    t_char            rn_byte;
    logic             rn_put, rn_newline, rn_scroll;
    logic [COL_W-1:0] rn_col;
    logic [ROW_W-1:0] rn_row;

    always_comb begin
        case (r_fl_idx)
            2'd0:    rn_byte = CH_ESC;
            2'd1:    rn_byte = CH_POS;
            default: rn_byte = r_held;
        endcase
        if (r_state != ST_FLUSH) begin
            rn_byte = r_char;
        end
        rn_put     = (rn_byte != CH_LF) && (rn_byte != CH_CR) && (rn_byte != '0);
        rn_newline = (rn_byte == CH_LF) || (rn_byte == CH_CR) ||
                     (rn_put && (r_col == COL_LAST));
        rn_scroll  = rn_newline && (r_row == ROW_LAST);
        if (rn_newline) begin
            rn_col = '0;
        end else if (rn_put) begin
            rn_col = r_col + COL_W'(1);
        end else begin
            rn_col = r_col;
        end
        rn_row = (rn_newline && !rn_scroll) ? r_row + ROW_W'(1) : r_row;
    end

    assign i_cmd.ready = (r_state == ST_IDLE);

    // Sequencer: next state, memory port and cursor updates
    always_comb begin
        n_state   = r_state;
        n_init    = r_init;
        n_col     = r_col;
        n_row     = r_row;
        n_phase   = r_phase;
        n_held    = r_held;
        n_char    = r_char;
        n_eos     = r_eos;
        n_cell_ok = r_cell_ok;
        n_fl_idx  = r_fl_idx;
        n_fl_last = r_fl_last;
        n_ptr     = r_ptr;
        n_end     = r_end;
        fin       = 1'b0;
        mem_re    = 1'b0;
        mem_ra    = r_ptr;
        // pending copy write of a scroll has the write port first
        mem_we    = r_cp_valid;
        mem_wa    = r_cp_addr;
        mem_wd    = r_rdata;

        unique case (r_state)
            ST_CLEAR: begin
                if (!r_cp_valid) begin
                    mem_we = 1'b1;
                    mem_wa = r_ptr;
                    mem_wd = '0;
                    if (r_ptr == r_end) begin
                        n_init  = 1'b0;
                        n_state = r_init ? ST_IDLE : ST_POST;
                    end else begin
                        n_ptr = r_ptr + CELL_W'(1);
                    end
                end
            end

            ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_char    = i_cmd.char_code;
                    n_eos     = i_cmd.end_of_string;
                    n_fl_idx  = '0;
                    n_fl_last = '0;
                    if (i_cmd.opcode == OP_READ) begin
                        n_cell_ok = rd_ok;
                        mem_re    = rd_ok;
                        mem_ra    = rd_addr;
                        n_state   = ST_DONE;
                    end else begin
                        n_cell_ok = 1'b0;
                        n_state   = ST_FEED;
                    end
                end
            end

            ST_FEED: begin
                if (r_char != '0) begin
                    unique case (r_phase)
                        PH_TEXT: begin
                            if (r_char == CH_ESC) begin
                                n_phase = PH_ESC;
                            end else begin
                                if (rn_put) begin
                                    mem_we = 1'b1;
                                    mem_wa = cur_addr;
                                    mem_wd = rn_byte;
                                end
                                n_col = rn_col;
                                n_row = rn_row;
                                if (rn_scroll) begin
                                    n_state = ST_SCROLL;
                                    n_ptr   = SCROLL_SRC;
                                end
                            end
                        end
                        PH_ESC: begin
                            n_phase = (r_char == CH_POS) ? PH_Y : PH_TEXT;
                            unique case (r_char)
                                CH_UP: begin
                                    if (r_row != '0) n_row = r_row - ROW_W'(1);
                                end
                                CH_DOWN: begin
                                    if (r_row != ROW_LAST) n_row = r_row + ROW_W'(1);
                                end
                                CH_RIGHT: begin
                                    if (r_col != COL_LAST) n_col = r_col + COL_W'(1);
                                end
                                CH_LEFT: begin
                                    if (r_col != '0) n_col = r_col - COL_W'(1);
                                end
                                CH_CLEAR: begin
                                    n_col   = '0;
                                    n_row   = '0;
                                    n_ptr   = '0;
                                    n_end   = CELL_LAST;
                                    n_state = ST_CLEAR;
                                end
                                CH_HOME: begin
                                    n_col = '0;
                                    n_row = '0;
                                end
                                CH_ERASE_EOS: begin
                                    n_ptr   = cur_addr;
                                    n_end   = CELL_LAST;
                                    n_state = ST_CLEAR;
                                end
                                CH_ERASE_EOL: begin
                                    n_ptr   = cur_addr;
                                    n_end   = eol_addr;
                                    n_state = ST_CLEAR;
                                end
                                default: begin
                                end
                            endcase
                        end
                        PH_Y: begin
                            n_held  = r_char;
                            n_phase = PH_YROW;
                        end
                        PH_YROW: begin
                            if (pos_ok) begin
                                n_row = ROW_W'(pos_r_diff[7:0]);
                                n_col = COL_W'(pos_c_diff[7:0]);
                            end
                            n_phase = PH_TEXT;
                        end
                        default: begin
                        end
                    endcase
                end
                // no sweep started: finish or go on to the flush check
                if (n_state == ST_FEED) begin
                    if (r_eos && (n_phase != PH_TEXT)) begin
                        n_state = ST_POST;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end

            ST_FLUSH: begin
                if (rn_put) begin
                    mem_we = 1'b1;
                    mem_wa = cur_addr;
                    mem_wd = rn_byte;
                end
                n_col    = rn_col;
                n_row    = rn_row;
                n_fl_idx = r_fl_idx + 2'd1;
                if (rn_scroll) begin
                    n_state = ST_SCROLL;
                    n_ptr   = SCROLL_SRC;
                end else begin
                    n_state = ST_POST;
                end
            end

            ST_POST: begin
                if (r_fl_idx != r_fl_last) begin
                    n_state = ST_FLUSH;
                end else if (r_eos && (r_phase != PH_TEXT)) begin
                    n_fl_idx  = '0;
                    n_fl_last = r_phase;
                    n_phase   = PH_TEXT;
                    n_state   = ST_FLUSH;
                end else begin
                    fin = 1'b1;
                end
            end

            ST_SCROLL: begin
                // read row below; the copy write lands in the next cycle
                mem_re = 1'b1;
                mem_ra = r_ptr;
                if (r_ptr == CELL_LAST) begin
                    n_ptr   = LAST_ROW0;
                    n_end   = CELL_LAST;
                    n_state = ST_CLEAR;
                end else begin
                    n_ptr = r_ptr + CELL_W'(1);
                end
            end

            ST_DONE: begin
                fin = 1'b1;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // hand result to the output register, or wait for it to free up
        out_load = fin && (!r_out_valid || o_rsp.ready);
        if (fin) begin
            n_state = out_load ? ST_IDLE : ST_DONE;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Control and cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= 1'b1;
            r_col       <= '0;
            r_row       <= '0;
            r_phase     <= PH_TEXT;
            r_held      <= '0;
            r_row_bias  <= ROW_BIAS_RST;
            r_col_bias  <= COL_BIAS_RST;
            r_fl_idx    <= '0;
            r_fl_last   <= '0;
            r_ptr       <= '0;
            r_end       <= CELL_LAST;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cell_ok   <= 1'b0;
        end else begin
            r_init     <= n_init;
            r_col      <= n_col;
            r_row      <= n_row;
            r_phase    <= n_phase;
            r_held     <= n_held;
            r_fl_idx   <= n_fl_idx;
            r_fl_last  <= n_fl_last;
            r_ptr      <= n_ptr;
            r_end      <= n_end;
            r_cp_valid <= (r_state == ST_SCROLL);
            r_cell_ok  <= n_cell_ok;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_ROW_BIAS: r_row_bias <= i_cfg_data;
                    CFG_COL_BIAS: r_col_bias <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_char    <= n_char;
        r_eos     <= n_eos;
        r_cp_addr <= r_ptr - SCROLL_SRC;
        if (out_load) begin
            r_o_col  <= 5'(n_col);
            r_o_row  <= 3'(n_row);
            r_o_cell <= r_cell_ok ? r_rdata : '0;
            r_o_esc  <= (n_phase != PH_TEXT);
        end
    end

    // Screen memory: one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.cursor_col     = r_o_col;
    assign o_rsp.cursor_row     = r_o_row;
    assign o_rsp.cell_char      = r_o_cell;
    assign o_rsp.escape_pending = r_o_esc;

endmodule
`default_nettype wire

// ----- sv/vt52_checker.sv -----
// Port-level checker of the text terminal, bound to the top level.
`default_nettype none
`include "vt52_text_terminal_top_defines.svh"
module vt52_checker import vt52_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    vt52_cmd_if.sink   i_cmd,
    vt52_rsp_if.source o_rsp
);

    logic       cmd_beat, rsp_beat;
    logic [1:0] r_pend;

    assign cmd_beat = i_cmd.valid && i_cmd.ready;
    assign rsp_beat = o_rsp.valid && o_rsp.ready;

    // Items accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (cmd_beat && !rsp_beat) begin
            r_pend <= r_pend + 2'd1;
        end else if (rsp_beat && !cmd_beat) begin
            r_pend <= r_pend - 2'd1;
        end
    end

    // Clearing pass keeps the command side closed right after reset
    `VT52_ASSERT_CLK(a_rst_not_ready, !i_rst_n |=> !i_cmd.ready, "ready during clear pass")
    // One result in the output register and one item in work at most
    `VT52_ASSERT_RUN(a_pend_max, r_pend != 2'd3, "too many items in flight")
    // No result without an accepted item behind it
    `VT52_ASSERT_RUN(a_no_spurious, r_pend == 2'd0 |-> !o_rsp.valid, "result without item")
    // A stalled result beat holds
    `VT52_ASSERT_RUN(a_rsp_hold, o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.cell_char) && $stable(o_rsp.cursor_col) && $stable(o_rsp.cursor_row) && $stable(o_rsp.escape_pending), "stalled result changed")

endmodule

bind vt52_text_terminal_top vt52_checker u_vt52_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_cmd   (i_cmd),
    .o_rsp   (o_rsp)
);
`default_nettype wire
